// ----- rtl/iptq_pkg.sv -----
package iptq_pkg;

  // Table geometry
  localparam int ENTRIES    = 64;
  localparam int IDX_BITS   = $clog2(ENTRIES);
  localparam int CNT_BITS   = IDX_BITS + 1;
  localparam int TASK_BITS  = 16;
  localparam int OWNER_BITS = 16;
  localparam int PRIO_BITS  = 32;
  localparam int OP_BITS    = 2;
  localparam int STAT_BITS  = 3;

  // Stream payload layout
  localparam int IN_RAW_W   = OP_BITS + TASK_BITS + OWNER_BITS + PRIO_BITS;
  localparam int IN_DATA_W  = ((IN_RAW_W + 7) / 8) * 8;
  localparam int OUT_RAW_W  = STAT_BITS + OWNER_BITS + TASK_BITS;
  localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

  // Operation codes
  localparam logic [OP_BITS-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_BITS-1:0] OP_EDIT   = 2'd1;
  localparam logic [OP_BITS-1:0] OP_REMOVE = 2'd2;
  localparam logic [OP_BITS-1:0] OP_EXEC   = 2'd3;

  // Result status codes
  localparam logic [STAT_BITS-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_BITS-1:0] ST_FULL      = 3'd1;
  localparam logic [STAT_BITS-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [STAT_BITS-1:0] ST_EMPTY     = 3'd3;
  localparam logic [STAT_BITS-1:0] ST_DUPLICATE = 3'd4;

  // Controller to datapath commands
  typedef struct packed {
    logic load;   // capture input item, restart scan
    logic step;   // issue next table read
    logic apply;  // commit table update and load result
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic scan_done;
    logic out_busy;
  } sts_t;

endpackage

// ----- rtl/indexed_priority_task_queue_top.sv -----
// Indexed priority task queue: holds up to 64 tasks (id, owner, priority).
// Input stream s_axis carries one operation per transfer: add, edit priority,
// remove by id, or execute top (highest priority, ties to the higher id).
// Output stream m_axis returns exactly one result per input transfer with a
// status code and, for a successful execute top, the task's owner and id.
// Each item is accepted, then the slot table is scanned one slot per cycle
// through the registered read port of the slot memories, then the update is
// committed. The next item is accepted in the cycle after commit, so a new
// item is taken only once the previous one has been committed. The single
// memory read per cycle during the scan bounds the throughput.
// Reset clears all slot valid bits and empties the output register; the slot
// contents need no clearing. When the receiver stalls, the result waits in
// the output register; a new item is still accepted and scanned, and only
// its commit waits until the pending result has been transferred.
module indexed_priority_task_queue_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [1:0] operation, [17:2] task_key, [33:18] owner, [65:34] prio_value
  input  logic [iptq_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [2:0] status, [18:3] owner_out, [34:19] task_out
  output logic [iptq_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import iptq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  iptq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  iptq_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

// ----- rtl/iptq_ctrl.sv -----
module iptq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  iptq_pkg::sts_t sts_i,
  output iptq_pkg::cmd_t cmd_o
);
  import iptq_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_APPLY = 2'd2;

  logic [1:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  // Sequence one item: accept, scan the table, commit
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.step = 1'b1;
        if (sts_i.scan_done) begin
          state_d = S_APPLY;
        end
      end
      S_APPLY: begin
        if (!sts_i.out_busy) begin
          cmd_o.apply = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/iptq_dp.sv -----
module iptq_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  iptq_pkg::cmd_t                  cmd_i,
  output iptq_pkg::sts_t                  sts_o,
  input  logic [iptq_pkg::IN_DATA_W-1:0]  in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [iptq_pkg::OUT_DATA_W-1:0] out_data_o
);
  import iptq_pkg::*;

  // Slot storage
  logic [ENTRIES-1:0]    slot_valid_q;
  logic [TASK_BITS-1:0]  task_mem  [ENTRIES];
  logic [OWNER_BITS-1:0] owner_mem [ENTRIES];
  logic [PRIO_BITS-1:0]  prio_mem  [ENTRIES];

  // Captured input item
  logic [OP_BITS-1:0]    op_q;
  logic [TASK_BITS-1:0]  key_q;
  logic [OWNER_BITS-1:0] usr_q;
  logic [PRIO_BITS-1:0]  pr_q;

  // Scan pipeline
  logic [CNT_BITS-1:0]   cnt_q;
  logic                  pend_q;
  logic [IDX_BITS-1:0]   rd_idx_q;
  logic                  rd_vld_q;
  logic [TASK_BITS-1:0]  rd_task_q;
  logic [OWNER_BITS-1:0] rd_owner_q;
  logic [PRIO_BITS-1:0]  rd_prio_q;

  // Scan results
  logic                  found_q;
  logic [IDX_BITS-1:0]   found_idx_q;
  logic                  free_q;
  logic [IDX_BITS-1:0]   free_idx_q;
  logic                  best_q;
  logic [IDX_BITS-1:0]   best_idx_q;
  logic [TASK_BITS-1:0]  best_task_q;
  logic [OWNER_BITS-1:0] best_owner_q;
  logic [PRIO_BITS-1:0]  best_prio_q;

  // Result register
  logic                  out_vld_q;
  logic [STAT_BITS-1:0]  res_stat_q;
  logic [OWNER_BITS-1:0] res_owner_q;
  logic [TASK_BITS-1:0]  res_task_q;

  logic                  issue;
  logic [IDX_BITS-1:0]   rd_addr;
  logic                  better;

  // Commit decode
  logic                  wr_all;
  logic                  wr_prio;
  logic                  set_vld;
  logic                  clr_vld;
  logic [IDX_BITS-1:0]   wr_idx;
  logic [STAT_BITS-1:0]  stat_d;

  assign issue   = cmd_i.step && (cnt_q != CNT_BITS'(ENTRIES));
  assign rd_addr = cnt_q[IDX_BITS-1:0];
  assign better  = !best_q || ({rd_prio_q, rd_task_q} > {best_prio_q, best_task_q});

  assign sts_o.scan_done = (cnt_q == CNT_BITS'(ENTRIES)) && !pend_q;
  assign sts_o.out_busy  = out_vld_q && !out_ready_i;

  assign out_valid_o = out_vld_q;
  assign out_data_o  = {{(OUT_DATA_W-OUT_RAW_W){1'b0}}, res_task_q, res_owner_q, res_stat_q};

  // Decide the table update and status for the current item
  always_comb begin
    wr_all  = 1'b0;
    wr_prio = 1'b0;
    set_vld = 1'b0;
    clr_vld = 1'b0;
    wr_idx  = found_idx_q;
    stat_d  = ST_OK;
    unique case (op_q)
      OP_ADD: begin
        wr_idx = free_idx_q;
        if (found_q) begin
          stat_d = ST_DUPLICATE;
        end else if (!free_q) begin
          stat_d = ST_FULL;
        end else begin
          wr_all  = 1'b1;
          set_vld = 1'b1;
        end
      end
      OP_EDIT: begin
        if (found_q) begin
          wr_prio = 1'b1;
        end else begin
          stat_d = ST_NOT_FOUND;
        end
      end
      OP_REMOVE: begin
        if (found_q) begin
          clr_vld = 1'b1;
        end else begin
          stat_d = ST_NOT_FOUND;
        end
      end
      OP_EXEC: begin
        wr_idx = best_idx_q;
        if (best_q) begin
          clr_vld = 1'b1;
        end else begin
          stat_d = ST_EMPTY;
        end
      end
      default: begin
        stat_d = ST_OK;
      end
    endcase
  end

  // Slot memories: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.apply && wr_all) begin
      task_mem[wr_idx]  <= key_q;
      owner_mem[wr_idx] <= usr_q;
    end
    if (cmd_i.apply && (wr_all || wr_prio)) begin
      prio_mem[wr_idx] <= pr_q;
    end
    if (issue) begin
      rd_task_q  <= task_mem[rd_addr];
      rd_owner_q <= owner_mem[rd_addr];
      rd_prio_q  <= prio_mem[rd_addr];
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_valid_q <= '0;
    end else if (cmd_i.apply) begin
      if (set_vld) begin
        slot_valid_q[wr_idx] <= 1'b1;
      end else if (clr_vld) begin
        slot_valid_q[wr_idx] <= 1'b0;
      end
    end
  end

  // Hold the input item
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= in_data_i[OP_BITS-1:0];
      key_q <= in_data_i[OP_BITS +: TASK_BITS];
      usr_q <= in_data_i[OP_BITS+TASK_BITS +: OWNER_BITS];
      pr_q  <= in_data_i[OP_BITS+TASK_BITS+OWNER_BITS +: PRIO_BITS];
    end
  end

  // Scan control: address counter, compare-stage flag and found, free and best flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      pend_q  <= 1'b0;
      found_q <= 1'b0;
      free_q  <= 1'b0;
      best_q  <= 1'b0;
    end else if (cmd_i.load) begin
      cnt_q   <= '0;
      pend_q  <= 1'b0;
      found_q <= 1'b0;
      free_q  <= 1'b0;
      best_q  <= 1'b0;
    end else begin
      pend_q <= issue;
      if (issue) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (pend_q) begin
        if (rd_vld_q && (rd_task_q == key_q)) begin
          found_q <= 1'b1;
        end
        if (!rd_vld_q) begin
          free_q <= 1'b1;
        end
        if (rd_vld_q) begin
          best_q <= 1'b1;
        end
      end
    end
  end

  // Scan payload: slot index, match, first free slot, running maximum
  always_ff @(posedge clk_i) begin
    if (issue) begin
      rd_idx_q <= rd_addr;
      rd_vld_q <= slot_valid_q[rd_addr];
    end
    if (pend_q && !cmd_i.load) begin
      if (rd_vld_q && (rd_task_q == key_q)) begin
        found_idx_q <= rd_idx_q;
      end
      if (!rd_vld_q && !free_q) begin
        free_idx_q <= rd_idx_q;
      end
      if (rd_vld_q && better) begin
        best_idx_q   <= rd_idx_q;
        best_task_q  <= rd_task_q;
        best_owner_q <= rd_owner_q;
        best_prio_q  <= rd_prio_q;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.apply) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.apply) begin
      res_stat_q <= stat_d;
      if ((op_q == OP_EXEC) && best_q) begin
        res_owner_q <= best_owner_q;
        res_task_q  <= best_task_q;
      end else begin
        res_owner_q <= '0;
        res_task_q  <= '0;
      end
    end
  end

endmodule

// ----- tb/tb_indexed_priority_task_queue_top.sv -----
module tb_indexed_priority_task_queue_top;
  timeunit 1ns;
  timeprecision 1ps;

  import iptq_pkg::*;

  localparam int TOTAL_ITEMS = 1300;
  localparam int DRAIN_WAIT  = 2 * (ENTRIES + 4);

  typedef struct packed {
    logic [STAT_BITS-1:0]  status;
    logic [OWNER_BITS-1:0] owner;
    logic [TASK_BITS-1:0]  task_id;
  } outcome_t;

  typedef struct packed {
    logic [OP_BITS-1:0]    op;
    logic [TASK_BITS-1:0]  key;
    logic [OWNER_BITS-1:0] owner;
    logic [PRIO_BITS-1:0]  prio;
  } request_t;

  // Directed row: request plus an optional hand-typed outcome
  typedef struct packed {
    request_t req;
    logic     typed;
    outcome_t want;
  } stim_row_t;

  typedef enum int {MIX_FILL, MIX_BALANCED, MIX_DRAIN} traffic_mix_e;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  // [1:0] operation, [17:2] task_key, [33:18] owner, [65:34] prio_value
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  // [2:0] status, [18:3] owner_out, [34:19] task_out
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  // Shadow copy of the slot table
  logic                  shadow_valid [ENTRIES];
  logic [TASK_BITS-1:0]  shadow_task  [ENTRIES];
  logic [OWNER_BITS-1:0] shadow_owner [ENTRIES];
  logic [PRIO_BITS-1:0]  shadow_prio  [ENTRIES];

  outcome_t  expected_outcomes[$];
  stim_row_t directed_rows[$];
  int        mismatch_count;
  int        send_idle_pct;
  int        recv_idle_pct;

  indexed_priority_task_queue_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Apply one operation to the shadow table and return its outcome
  function automatic outcome_t apply_queue_op(input request_t req);
    outcome_t res;
    int       hit;
    int       spot;
    int       best;
    res  = '{status: ST_OK, owner: '0, task_id: '0};
    hit  = -1;
    spot = -1;
    best = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (shadow_valid[i] && shadow_task[i] == req.key) hit = i;
      if (!shadow_valid[i] && spot < 0) spot = i;
    end
    case (req.op)
      OP_ADD: begin
        if (hit >= 0) begin
          res.status = ST_DUPLICATE;
        end else if (spot < 0) begin
          res.status = ST_FULL;
        end else begin
          shadow_valid[spot] = 1'b1;
          shadow_task[spot]  = req.key;
          shadow_owner[spot] = req.owner;
          shadow_prio[spot]  = req.prio;
        end
      end
      OP_EDIT: begin
        if (hit < 0) res.status = ST_NOT_FOUND;
        else shadow_prio[hit] = req.prio;
      end
      OP_REMOVE: begin
        if (hit < 0) res.status = ST_NOT_FOUND;
        else shadow_valid[hit] = 1'b0;
      end
      default: begin
        // Highest priority wins, ties go to the higher id
        for (int i = 0; i < ENTRIES; i++) begin
          if (shadow_valid[i]) begin
            if (best < 0 || shadow_prio[i] > shadow_prio[best] ||
                (shadow_prio[i] == shadow_prio[best] &&
                 shadow_task[i] > shadow_task[best]))
              best = i;
          end
        end
        if (best < 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.owner          = shadow_owner[best];
          res.task_id        = shadow_task[best];
          shadow_valid[best] = 1'b0;
        end
      end
    endcase
    return res;
  endfunction

  function automatic int live_count();
    int n;
    n = 0;
    for (int i = 0; i < ENTRIES; i++) if (shadow_valid[i]) n++;
    return n;
  endfunction

  // Task id: often a live one, often from a small colliding pool
  function automatic logic [TASK_BITS-1:0] pick_key();
    int                   r;
    int                   idx;
    logic [TASK_BITS-1:0] k;
    r = $urandom_range(99);
    if (r < 50 && live_count() > 0) begin
      do idx = $urandom_range(ENTRIES - 1); while (!shadow_valid[idx]);
      k = shadow_task[idx];
    end else if (r < 80) begin
      k = TASK_BITS'($urandom_range(31));
      if ($urandom_range(1)) k = k ^ {TASK_BITS{1'b1}};
    end else begin
      k = TASK_BITS'($urandom);
    end
    return k;
  endfunction

  // Priority: small values for ties, extremes, or anything
  function automatic logic [PRIO_BITS-1:0] pick_prio();
    int r;
    r = $urandom_range(99);
    if (r < 30) return PRIO_BITS'($urandom_range(7));
    if (r < 40) return $urandom_range(1) ? {PRIO_BITS{1'b1}} : '0;
    return PRIO_BITS'($urandom);
  endfunction

  function automatic request_t random_request(input traffic_mix_e mix);
    request_t req;
    int       r;
    int       add_w;
    int       edit_w;
    int       rem_w;
    case (mix)
      MIX_FILL:     begin add_w = 90; edit_w = 4;  rem_w = 3;  end
      MIX_BALANCED: begin add_w = 35; edit_w = 25; rem_w = 15; end
      default:      begin add_w = 10; edit_w = 15; rem_w = 30; end
    endcase
    req.owner = OWNER_BITS'($urandom);
    // A few items carry fully random fields
    if ($urandom_range(99) < 5) begin
      req.op   = OP_BITS'($urandom);
      req.key  = TASK_BITS'($urandom);
      req.prio = PRIO_BITS'($urandom);
      return req;
    end
    r = $urandom_range(99);
    if (r < add_w) req.op = OP_ADD;
    else if (r < add_w + edit_w) req.op = OP_EDIT;
    else if (r < add_w + edit_w + rem_w) req.op = OP_REMOVE;
    else req.op = OP_EXEC;
    req.key  = pick_key();
    req.prio = pick_prio();
    return req;
  endfunction

  function automatic stim_row_t mk_row(input logic [OP_BITS-1:0] op,
                                       input logic [TASK_BITS-1:0] key,
                                       input logic [OWNER_BITS-1:0] owner,
                                       input logic [PRIO_BITS-1:0] prio,
                                       input logic typed,
                                       input logic [STAT_BITS-1:0] st,
                                       input logic [OWNER_BITS-1:0] own_o,
                                       input logic [TASK_BITS-1:0] task_o);
    stim_row_t row;
    row.req   = '{op: op, key: key, owner: owner, prio: prio};
    row.typed = typed;
    row.want  = '{status: st, owner: own_o, task_id: task_o};
    return row;
  endfunction

  // Drive one request at the falling edge and hold it until transferred
  task automatic send_request(input request_t req, input logic typed,
                              input outcome_t typed_want);
    outcome_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_DATA_W'({req.prio, req.owner, req.key, req.op});
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = apply_queue_op(req);
    expected_outcomes.push_back(typed ? typed_want : predicted);
    @(negedge clk_i);
  endtask

  // Receiver backpressure
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Check each result transfer against the oldest expectation
  always @(posedge clk_i) begin : result_check
    outcome_t got;
    outcome_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{status:  m_axis_tdata[2:0],
              owner:   m_axis_tdata[18:3],
              task_id: m_axis_tdata[34:19]};
      if (expected_outcomes.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result: status %0d owner %h task %h",
                 $time, got.status, got.owner, got.task_id);
      end else begin
        want = expected_outcomes.pop_front();
        if (got.status !== want.status) begin
          mismatch_count++;
          $display("%0t: status mismatch: expected %0d actual %0d",
                   $time, want.status, got.status);
        end
        if (got.owner !== want.owner) begin
          mismatch_count++;
          $display("%0t: owner_out mismatch: expected %h actual %h",
                   $time, want.owner, got.owner);
        end
        if (got.task_id !== want.task_id) begin
          mismatch_count++;
          $display("%0t: task_out mismatch: expected %h actual %h",
                   $time, want.task_id, got.task_id);
        end
      end
    end
  end

  // Main stimulus
  initial begin : stimulus
    traffic_mix_e mix;
    int           sent;
    int           burst_left;
    int           tail_left;
    request_t     req;
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    m_axis_tready  = 1'b0;
    mismatch_count = 0;
    send_idle_pct  = 13;
    recv_idle_pct  = 78;
    for (int i = 0; i < ENTRIES; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_task[i]  = '0;
      shadow_owner[i] = '0;
      shadow_prio[i]  = '0;
    end

    // Directed rows: empty queue, misses, extremes, ties, duplicates
    directed_rows.push_back(mk_row(OP_EXEC,   16'h0000, 16'h0000, 32'h0000_0000,
                                   1'b1, ST_EMPTY, 16'h0000, 16'h0000));
    directed_rows.push_back(mk_row(OP_EDIT,   16'h0000, 16'hFFFF, 32'hFFFF_FFFF,
                                   1'b1, ST_NOT_FOUND, 16'h0000, 16'h0000));
    directed_rows.push_back(mk_row(OP_REMOVE, 16'hFFFF, 16'h0000, 32'h0000_0000,
                                   1'b1, ST_NOT_FOUND, 16'h0000, 16'h0000));
    directed_rows.push_back(mk_row(OP_ADD,    16'h0000, 16'h0000, 32'h0000_0000,
                                   1'b1, ST_OK, 16'h0000, 16'h0000));
    directed_rows.push_back(mk_row(OP_ADD,    16'h0000, 16'hFFFF, 32'hFFFF_FFFF,
                                   1'b1, ST_DUPLICATE, 16'h0000, 16'h0000));
    directed_rows.push_back(mk_row(OP_ADD,    16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF,
                                   1'b1, ST_OK, 16'h0000, 16'h0000));
    directed_rows.push_back(mk_row(OP_ADD,    16'h1234, 16'hABCD, 32'hFFFF_FFFF,
                                   1'b1, ST_OK, 16'h0000, 16'h0000));
    directed_rows.push_back(mk_row(OP_EXEC,   16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF,
                                   1'b1, ST_OK, 16'hFFFF, 16'hFFFF));
    directed_rows.push_back(mk_row(OP_EXEC,   16'h0000, 16'h0000, 32'h0000_0000,
                                   1'b1, ST_OK, 16'hABCD, 16'h1234));
    directed_rows.push_back(mk_row(OP_EXEC,   16'h0000, 16'h0000, 32'h0000_0000,
                                   1'b1, ST_OK, 16'h0000, 16'h0000));
    directed_rows.push_back(mk_row(OP_EXEC,   16'h0000, 16'h0000, 32'h0000_0000,
                                   1'b1, ST_EMPTY, 16'h0000, 16'h0000));
    directed_rows.push_back(mk_row(OP_ADD,    16'h8000, 16'h5555, 32'h8000_0000,
                                   1'b0, ST_OK, '0, '0));
    directed_rows.push_back(mk_row(OP_ADD,    16'h7FFF, 16'hAAAA, 32'h7FFF_FFFF,
                                   1'b0, ST_OK, '0, '0));
    directed_rows.push_back(mk_row(OP_EDIT,   16'h7FFF, 16'h0000, 32'hFFFF_FFFF,
                                   1'b0, ST_OK, '0, '0));
    directed_rows.push_back(mk_row(OP_ADD,    16'h0001, 16'h0F0F, 32'h8000_0000,
                                   1'b0, ST_OK, '0, '0));
    directed_rows.push_back(mk_row(OP_EXEC,   16'h0000, 16'h0000, 32'h0000_0000,
                                   1'b0, ST_OK, '0, '0));
    directed_rows.push_back(mk_row(OP_EDIT,   16'h8000, 16'h0000, 32'h0000_0000,
                                   1'b0, ST_OK, '0, '0));
    directed_rows.push_back(mk_row(OP_EXEC,   16'h0000, 16'h0000, 32'h0000_0000,
                                   1'b0, ST_OK, '0, '0));
    directed_rows.push_back(mk_row(OP_REMOVE, 16'h8000, 16'h0000, 32'h0000_0000,
                                   1'b1, ST_OK, 16'h0000, 16'h0000));
    directed_rows.push_back(mk_row(OP_REMOVE, 16'h8000, 16'h0000, 32'h0000_0000,
                                   1'b1, ST_NOT_FOUND, 16'h0000, 16'h0000));
    directed_rows.push_back(mk_row(OP_EXEC,   16'h0000, 16'h0000, 32'h0000_0000,
                                   1'b1, ST_EMPTY, 16'h0000, 16'h0000));
    directed_rows.push_back(mk_row(OP_EDIT,   16'hFFFF, 16'hFFFF, 32'h0000_0000,
                                   1'b1, ST_NOT_FOUND, 16'h0000, 16'h0000));

    // Hold reset, then release it at a falling edge
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i])
      send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);

    // Random bursts; fill bursts run until the table overflows a little
    sent       = directed_rows.size();
    burst_left = 0;
    tail_left  = 0;
    mix        = MIX_FILL;
    while (sent < TOTAL_ITEMS) begin
      if (sent == TOTAL_ITEMS / 3) begin
        send_idle_pct = 78;
        recv_idle_pct = 13;
      end else if (sent == 2 * TOTAL_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (burst_left == 0) begin
        case ($urandom_range(2))
          0:       mix = MIX_FILL;
          1:       mix = MIX_BALANCED;
          default: mix = MIX_DRAIN;
        endcase
        burst_left = (mix == MIX_FILL) ? 400 : $urandom_range(20, 150);
        tail_left  = $urandom_range(3, 12);
      end
      req = random_request(mix);
      send_request(req, 1'b0, '0);
      sent++;
      burst_left--;
      if (mix == MIX_FILL && live_count() == ENTRIES) begin
        if (tail_left == 0) burst_left = 0;
        else tail_left--;
      end
    end
    s_axis_tvalid <= 1'b0;

    // Drain outstanding results
    while (expected_outcomes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (mismatch_count == 0 && expected_outcomes.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #8_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
